// ----- sv/tfl_pkg.sv -----
// Shared types and constants for the three-axis FIR low-pass block.
// Used by the tap cells, the sum stage and the top level; no dependencies.
`default_nettype none

package tfl_pkg;

    localparam int TAPS        = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int FRAC_BITS   = 15;
    localparam int NUM_COEFFS  = 4;
    localparam int CFG_IDX_BITS = $clog2(NUM_COEFFS);
    localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_BITS    = PROD_BITS + $clog2(TAPS);

    // Register indexes of the coefficient bank
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_NEWEST      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_DELAY_ONE   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_DELAY_TWO   = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_DELAY_THREE = CFG_IDX_BITS'(3);

    // Reset weights in Q1.15: 0.5, 0.25, 0.125, 0.125
    localparam logic signed [COEFF_BITS-1:0] COEFF_HALF    = COEFF_BITS'(16384);
    localparam logic signed [COEFF_BITS-1:0] COEFF_QUARTER = COEFF_BITS'(8192);
    localparam logic signed [COEFF_BITS-1:0] COEFF_EIGHTH  = COEFF_BITS'(4096);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEFF_BITS-1:0]  t_coeff;
    typedef logic signed [PROD_BITS-1:0]   t_prod_val;
    typedef logic signed [ACC_BITS-1:0]    t_acc;

    typedef struct packed {
        t_sample sample_x;
        t_sample sample_y;
        t_sample sample_z;
    } t_in;

    typedef struct packed {
        t_sample filtered_x;
        t_sample filtered_y;
        t_sample filtered_z;
    } t_out;

    typedef struct packed {
        t_prod_val prod_x;
        t_prod_val prod_y;
        t_prod_val prod_z;
    } t_prod;

    // Pipeline strobes handed to every tap cell
    typedef struct packed {
        logic shift;   // request accepted: advance the delay line
        logic load;    // capture new products
    } t_cell_ctrl;

    function automatic t_coeff coeff_reset(input logic [CFG_IDX_BITS-1:0] idx);
        t_coeff val;
        case (idx)
            REG_COEFF_NEWEST:      val = COEFF_HALF;
            REG_COEFF_DELAY_ONE:   val = COEFF_QUARTER;
            REG_COEFF_DELAY_TWO:   val = COEFF_EIGHTH;
            REG_COEFF_DELAY_THREE: val = COEFF_EIGHTH;
            default:               val = COEFF_EIGHTH;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tfl_cell.sv -----
// One tap of the FIR chain: weights the sample it sees and delays it for the
// next tap. Depends on tfl_pkg for the sample, product and control types.
`default_nettype none

module tfl_cell
    import tfl_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_in        i_tap,
    input  t_coeff     i_coeff,
    output t_in        o_tap,
    output t_prod      o_prod
);

    t_in   r_hist;
    t_prod r_prod;

    // Delay the sample by one request for the neighbor cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctrl.shift) begin
            r_hist <= i_tap;
        end
    end

    // Weight each axis by this tap's coefficient
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod.prod_x <= i_tap.sample_x * i_coeff;
            r_prod.prod_y <= i_tap.sample_y * i_coeff;
            r_prod.prod_z <= i_tap.sample_z * i_coeff;
        end
    end

    assign o_tap  = r_hist;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/tfl_sum.sv -----
// Output stage: adds the tap products per axis, floors by 2^15 and saturates.
// Depends on tfl_pkg for the product and result types.
`default_nettype none

module tfl_sum
    import tfl_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_load,
    input  t_prod i_prod [TAPS],
    output t_out  o_result
);

    localparam t_acc SAT_HI = t_acc'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam t_acc SAT_LO = -SAT_HI - t_acc'(1);

    t_out r_result;
    t_out n_result;

    // Floor toward minus infinity, then clamp to the sample range
    function automatic t_sample scale_sat(input t_acc acc);
        t_acc    shifted;
        t_sample val;
        shifted = acc >>> FRAC_BITS;
        if (shifted > SAT_HI) begin
            val = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            val = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            val = shifted[SAMPLE_BITS-1:0];
        end
        return val;
    endfunction

    // Sum the taps of each axis
    always_comb begin
        t_acc acc_x;
        t_acc acc_y;
        t_acc acc_z;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        for (int k = 0; k < TAPS; k++) begin
            acc_x = acc_x + t_acc'(i_prod[k].prod_x);
            acc_y = acc_y + t_acc'(i_prod[k].prod_y);
            acc_z = acc_z + t_acc'(i_prod[k].prod_z);
        end
        n_result.filtered_x = scale_sat(acc_x);
        n_result.filtered_y = scale_sat(acc_y);
        n_result.filtered_z = scale_sat(acc_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- sv/three_axis_fir_lowpass.sv -----
// Top level of the three-axis FIR low-pass: coefficient bank, tap chain and
// handshake control. Depends on tfl_pkg, tfl_cell and tfl_sum.
`default_nettype none

// Each request carries one x,y,z sample triple; each axis runs through the
// same four-tap FIR (newest sample times coefficient 0, oldest times
// coefficient 3), and the result is floored to an integer and saturated to
// 16 bits. A new request is accepted every cycle while results are taken.
// Tap cells register a request's products at the edge that accepts it; the
// sum stage adds, floors and saturates them into the output register when
// that is free or being read. The input side keeps accepting while one
// finished result waits on the output; a second request then waits until
// that result is taken. Ready stays low while reset is held. Coefficients
// are written through the plain write port (index 0 to 3, Q1.15) while no
// request is in flight, a rule the block leaves to the user; the delay lines
// clear to zero and the coefficients to 0.5, 0.25, 0.125 and 0.125 at reset.

module three_axis_fir_lowpass
    import tfl_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  t_in                    i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output t_out                   o_out_data,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire [COEFF_BITS-1:0]   i_cfg_data
);

    t_coeff     r_coeff [NUM_COEFFS];
    logic       r_v1;
    logic       r_v2;
    logic       w_adv2;
    t_cell_ctrl w_ctrl;
    t_in        w_tap  [TAPS];
    t_prod      w_prod [TAPS];

    // Hold the coefficient bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFFS; k++) begin
                r_coeff[k] <= coeff_reset(CFG_IDX_BITS'(k));
            end
        end else if (i_cfg_we) begin
            r_coeff[i_cfg_index] <= i_cfg_data;
        end
    end

    // Advance the two stages; the product stage refills while a result waits
    assign w_adv2       = !r_v2 || i_out_ready;
    assign o_in_ready   = i_rst_n && (!r_v1 || w_adv2);
    assign w_ctrl.shift = i_in_valid && o_in_ready;
    assign w_ctrl.load  = o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign w_tap[0] = i_in_data;

    // Build the tap chain; taps past the register bank weigh zero
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        t_coeff w_coeff;
        t_in    w_next;
        if (k < NUM_COEFFS) begin : g_reg
            assign w_coeff = r_coeff[k];
        end else begin : g_zero
            assign w_coeff = '0;
        end
        tfl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_tap   (w_tap[k]),
            .i_coeff (w_coeff),
            .o_tap   (w_next),
            .o_prod  (w_prod[k])
        );
        if (k < TAPS - 1) begin : g_link
            assign w_tap[k+1] = w_next;
        end
    end

    tfl_sum u_sum (
        .i_clk    (i_clk),
        .i_load   (w_adv2),
        .i_prod   (w_prod),
        .o_result (o_out_data)
    );

    assign o_out_valid = r_v2;

endmodule

`default_nettype wire

// ----- test/three_axis_fir_lowpass_test.sv -----
// Self-checking testbench for three_axis_fir_lowpass: a scoreboard predicts every filtered
// triple from its own copy of the delay lines and coefficients and checks each result.
// Depends on tfl_pkg and the three_axis_fir_lowpass RTL.
`default_nettype none

module three_axis_fir_lowpass_test;
    import tfl_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int ITEMS_PER_SET = 66;
    localparam int NUM_SETS      = 8;
    localparam int DRAIN_CYCLES  = 4;
    localparam int MAX_PRINTED   = 30;

    // Predicts filtered triples and checks them in order
    class fir_triple_board;
        t_coeff  weight [NUM_COEFFS];
        t_sample history [3][TAPS-1];
        t_out    expected_triples [$];
        int      errors;
        int      requests;
        int      results;

        function new();
            weight[REG_COEFF_NEWEST]      = COEFF_HALF;
            weight[REG_COEFF_DELAY_ONE]   = COEFF_QUARTER;
            weight[REG_COEFF_DELAY_TWO]   = COEFF_EIGHTH;
            weight[REG_COEFF_DELAY_THREE] = COEFF_EIGHTH;
            foreach (history[a, k]) history[a][k] = '0;
            errors   = 0;
            requests = 0;
            results  = 0;
        endfunction

        function void set_coeff(input logic [CFG_IDX_BITS-1:0] idx, input t_coeff value);
            weight[idx] = value;
        endfunction

        // Weighted sum of one axis, floored and clamped; then advance its delay line
        function t_sample filter_axis(input int axis, input t_sample cur);
            longint acc;
            longint sat_hi;
            longint sat_lo;
            t_sample res;
            sat_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            sat_lo = -sat_hi - 1;
            acc = longint'(cur) * longint'(weight[0]);
            for (int k = 1; k < TAPS; k++) begin
                acc += longint'(history[axis][k-1]) * longint'(weight[k]);
            end
            acc = acc >>> FRAC_BITS;
            if (acc > sat_hi) begin
                res = t_sample'(sat_hi);
            end else if (acc < sat_lo) begin
                res = t_sample'(sat_lo);
            end else begin
                res = t_sample'(acc);
            end
            for (int k = TAPS - 2; k > 0; k--) begin
                history[axis][k] = history[axis][k-1];
            end
            history[axis][0] = cur;
            return res;
        endfunction

        function void note_request(input t_in req);
            t_out exp_val;
            exp_val.filtered_x = filter_axis(0, req.sample_x);
            exp_val.filtered_y = filter_axis(1, req.sample_y);
            exp_val.filtered_z = filter_axis(2, req.sample_z);
            expected_triples.push_back(exp_val);
            requests++;
        endfunction

        function int pending();
            return expected_triples.size();
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        task check_result(input t_out got);
            t_out exp_val;
            if (expected_triples.size() == 0) begin
                report($sformatf("result %0d %0d %0d with nothing expected",
                    got.filtered_x, got.filtered_y, got.filtered_z));
            end else begin
                exp_val = expected_triples.pop_front();
                if (got.filtered_x !== exp_val.filtered_x) begin
                    report($sformatf("result %0d filtered_x got %0d want %0d",
                        results, got.filtered_x, exp_val.filtered_x));
                end
                if (got.filtered_y !== exp_val.filtered_y) begin
                    report($sformatf("result %0d filtered_y got %0d want %0d",
                        results, got.filtered_y, exp_val.filtered_y));
                end
                if (got.filtered_z !== exp_val.filtered_z) begin
                    report($sformatf("result %0d filtered_z got %0d want %0d",
                        results, got.filtered_z, exp_val.filtered_z));
                end
            end
            results++;
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    t_in                     i_in_data   = '0;
    logic                    i_out_ready = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = REG_COEFF_NEWEST;
    logic [COEFF_BITS-1:0]   i_cfg_data  = '0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    t_out                    o_out_data;

    fir_triple_board board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    three_axis_fir_lowpass uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result side at the phase's rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_data);
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("three_axis_fir_lowpass_test: FAIL");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until taken
    task send_sample(input int x, input int y, input int z);
        t_in req;
        req.sample_x = t_sample'(x);
        req.sample_y = t_sample'(y);
        req.sample_z = t_sample'(z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(req);
    endtask

    // Drop valid and wait for every expected result, then for the pipeline to settle
    task drain_block();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four coefficients on consecutive cycles
    task program_coeffs(input t_coeff c [NUM_COEFFS]);
        logic [CFG_IDX_BITS-1:0] regs [NUM_COEFFS];
        regs = '{REG_COEFF_NEWEST, REG_COEFF_DELAY_ONE,
                 REG_COEFF_DELAY_TWO, REG_COEFF_DELAY_THREE};
        for (int k = 0; k < NUM_COEFFS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= c[k];
            @(posedge i_clk);
            board.set_coeff(regs[k], c[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mix of extremes, tiny values and full-range noise
    function automatic int pick_sample();
        int v;
        case ($urandom_range(9))
            0:       v = 32767;
            1:       v = -32768;
            2:       v = 0;
            3:       v = -1;
            4:       v = int'($urandom_range(64)) - 32;
            default: v = int'(t_sample'($urandom));
        endcase
        return v;
    endfunction

    initial begin
        t_coeff cset [NUM_COEFFS];
        int     sets_run;

        sets_run = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_SETS; phase++) begin
            // Pick the coefficient set; the first phase runs on reset values
            if (phase > 0) begin
                case (phase)
                    1:       cset = '{32767, 32767, 32767, 32767};
                    2:       cset = '{-32768, -32768, -32768, -32768};
                    3:       cset = '{32767, -32768, 32767, -32768};
                    4:       cset = '{-32768, 0, 0, 0};
                    default: foreach (cset[k]) cset[k] = t_coeff'($urandom);
                endcase
                program_coeffs(cset);
            end
            sets_run++;

            // Pick how often each side idles
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase

            if (phase == 0) begin
                // Field extremes, steady states, sign flips, floor on negatives, impulse
                send_sample(0, 0, 0);
                repeat (4) send_sample(32767, -32768, -1);
                repeat (4) send_sample(-32768, 32767, 1);
                send_sample(1, -1, 0);
                repeat (2) send_sample(-1, -1, -1);
                send_sample(32767, 32767, -32768);
                repeat (3) send_sample(0, 0, 0);
                send_sample(16'h5555, -21846, 16'h00ff);
                send_sample(-21846, 16'h5555, -256);
                send_sample(-3, 3, -32767);
            end

            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                send_sample(pick_sample(), pick_sample(), pick_sample());
            end
            drain_block();
        end

        if (board.pending() != 0) begin
            board.report($sformatf("%0d expected results never arrived", board.pending()));
        end
        $display("summary: %0d requests under %0d coefficient sets, %0d results checked",
            board.requests, sets_run, board.results);
        $display("summary: %0d mismatches across four idle patterns", board.errors);
        if (board.errors == 0) begin
            $display("three_axis_fir_lowpass_test: PASS");
        end else begin
            $display("three_axis_fir_lowpass_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
